@@ src/masked_byte_search_replace_assert.svh @@
// Assertion macros shared by the search and replace modules.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef MASKED_BYTE_SEARCH_REPLACE_ASSERT_SVH
`define MASKED_BYTE_SEARCH_REPLACE_ASSERT_SVH

// Same-cycle implication
`define MSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/msr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msr_pkg
// Types, register indexes and helpers shared by the masked byte search and
// replace controller, datapath and top level.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam logic [7:0] BYTE_MASK = 8'hff;

  // Counts of held or emitted bytes (0..8)
  typedef logic [3:0] cnt_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SEARCH_PATTERN  = 3'd0,
    REG_SEARCH_MASK     = 3'd1,
    REG_SEARCH_LENGTH   = 3'd2,
    REG_REPLACE_PATTERN = 3'd3,
    REG_REPLACE_MASK    = 3'd4,
    REG_REPLACE_LENGTH  = 3'd5,
    REG_SPLICE_LENGTH   = 3'd6
  } cfg_reg_e;

  // Decision for the item at the input, datapath to controller
  typedef struct packed {
    cnt_t emit_cnt;  // results this item causes
    logic repl;      // results are replacement bytes
  } dp_status_t;

  // Commands, controller to datapath
  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic load;    // load the output register
    logic last;    // loaded byte ends the run
    logic repl;    // loaded byte comes from the replacement
    cnt_t idx;     // byte position within the run
  } dp_cmd_t;

  // Byte i of a 64-bit word
  function automatic logic [7:0] byte_sel(input logic [63:0] word, input logic [2:0] i);
    byte_sel = 8'(word >> {i, 3'b000}) & BYTE_MASK;
  endfunction

endpackage
`default_nettype wire

@@ src/msr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer: takes one input item, then walks the results it causes out
// through the output register one byte per free slot.
// ----------------------------------------------------------------------------
`include "masked_byte_search_replace_assert.svh"

module msr_ctrl
  import msr_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire             out_stall,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   k_r, k_nxt;
  cnt_t   n_r, n_nxt;
  logic   repl_r, repl_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   last_byte;

  assign slot_free = !out_valid_r || !out_stall;
  assign last_byte = (k_r == 4'(n_r - 4'd1));

  // Commands to the datapath
  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.load   = (state_r == S_EMIT) && slot_free;
    cmd.last   = last_byte;
    cmd.repl   = repl_r;
    cmd.idx    = k_r;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    repl_nxt      = repl_r;
    out_valid_nxt = cmd.load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && (st.emit_cnt != 4'd0)) begin
          state_nxt = S_EMIT;
          k_nxt     = 4'd0;
          n_nxt     = st.emit_cnt;
          repl_nxt  = st.repl;
        end
      end
      S_EMIT: begin
        if (cmd.load) begin
          k_nxt = 4'(k_r + 4'd1);
          if (last_byte) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 4'd0;
      n_r         <= 4'd0;
      repl_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      repl_r      <= repl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MSR_ASSERT_NOW(a_idx_in_run, state_r == S_EMIT, k_r < n_r, "emit index past run length")
  `MSR_ASSERT_NEXT(a_silent_idle, cmd.accept && ~|st.emit_cnt, state_r == S_IDLE, "silent item")
  `MSR_ASSERT_NEXT(a_last_ends, cmd.load && cmd.last, state_r == S_IDLE && out_valid_r, "run open")

endmodule
`default_nettype wire

@@ src/msr_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msr_dp
// Datapath: configuration registers, held bytes, match position and count,
// masked compare, splice logic and the output payload register.
// ----------------------------------------------------------------------------
`include "masked_byte_search_replace_assert.svh"

module msr_dp
  import msr_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_wr_en,
  input  wire  [2:0]   cfg_index,
  input  wire  [63:0]  cfg_wdata,
  input  wire          in_func,
  input  wire  [7:0]   in_data_byte,
  input  wire dp_cmd_t cmd,
  output dp_status_t   st,
  output logic [7:0]   out_byte,
  output logic         out_last_of_run,
  output logic         out_from_replacement,
  output logic [31:0]  out_match_total
);

  localparam int   IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam cnt_t MAX_L = 4'(MAX_PATTERN);

  logic [63:0] search_pattern_r, search_mask_r, replace_pattern_r, replace_mask_r;
  cnt_t        search_length_r, replace_length_r, splice_length_r;

  logic [7:0]  held_r [MAX_PATTERN];
  cnt_t        mp_r, mp_nxt;
  logic [31:0] count_r, count_nxt;

  logic [7:0]  out_byte_r;
  logic        out_last_r, out_repl_r;
  logic [31:0] out_total_r;

  cnt_t        slen, rlen, splen, pos, pos_inc;
  logic [7:0]  pat_b, msk_b, held_b, rep_b, rmsk_b, emit_b;
  logic        hit, full;

  // Clamp lengths to their usable ranges
  always_comb begin
    slen = search_length_r;
    if (slen == 4'd0) slen = 4'd1;
    if (slen > MAX_L) slen = MAX_L;
    rlen = (replace_length_r > MAX_L) ? MAX_L : replace_length_r;
    splen = splice_length_r;
    if (splen > slen) splen = slen;
    if (splen > rlen) splen = rlen;
    pos     = (mp_r >= MAX_L) ? 4'(MAX_L - 4'd1) : mp_r;
    pos_inc = 4'(pos + 4'd1);
  end

  // Masked compare of the incoming byte at the current position
  assign pat_b = byte_sel(search_pattern_r, pos[2:0]);
  assign msk_b = byte_sel(search_mask_r, pos[2:0]);
  assign hit   = (((in_data_byte ^ pat_b) & msk_b) == 8'h00);
  assign full  = !in_func && hit && (pos_inc >= slen);

  // Decide what the item at the input causes
  always_comb begin
    st.emit_cnt = 4'd0;
    st.repl     = 1'b0;
    if (in_func) begin
      st.emit_cnt = pos;
    end else if (!hit) begin
      st.emit_cnt = pos_inc;
    end else if (full) begin
      st.emit_cnt = rlen;
      st.repl     = 1'b1;
    end
  end

  // Advance match position and count
  always_comb begin
    mp_nxt    = mp_r;
    count_nxt = count_r;
    if (cmd.accept) begin
      mp_nxt = (in_func || !hit || full) ? 4'd0 : pos_inc;
      if (full) count_nxt = count_r + 32'd1;
    end
  end

  // Emitted byte: held byte, or replacement spliced with the matched byte
  assign held_b = held_r[cmd.idx[IDX_W-1:0]];
  assign rep_b  = byte_sel(replace_pattern_r, cmd.idx[2:0]);
  assign rmsk_b = byte_sel(replace_mask_r, cmd.idx[2:0]);
  always_comb begin
    if (!cmd.repl) begin
      emit_b = held_b;
    end else if (cmd.idx < splen) begin
      emit_b = (rep_b & rmsk_b) | (held_b & ~rmsk_b);
    end else begin
      emit_b = rep_b;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_pattern_r  <= 64'd0;
      search_mask_r     <= {64{1'b1}};
      search_length_r   <= 4'd1;
      replace_pattern_r <= 64'd0;
      replace_mask_r    <= 64'd0;
      replace_length_r  <= 4'd0;
      splice_length_r   <= 4'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SEARCH_PATTERN:  search_pattern_r  <= cfg_wdata;
        REG_SEARCH_MASK:     search_mask_r     <= cfg_wdata;
        REG_SEARCH_LENGTH:   search_length_r   <= cfg_wdata[3:0];
        REG_REPLACE_PATTERN: replace_pattern_r <= cfg_wdata;
        REG_REPLACE_MASK:    replace_mask_r    <= cfg_wdata;
        REG_REPLACE_LENGTH:  replace_length_r  <= cfg_wdata[3:0];
        REG_SPLICE_LENGTH:   splice_length_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Match state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r    <= 4'd0;
      count_r <= 32'd0;
    end else begin
      mp_r    <= mp_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the incoming data byte
  always_ff @(posedge clk) begin
    if (cmd.accept && !in_func) begin
      held_r[pos[IDX_W-1:0]] <= in_data_byte;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r  <= emit_b;
      out_last_r  <= cmd.last;
      out_repl_r  <= cmd.repl;
      out_total_r <= count_r;
    end
  end

  assign out_byte             = out_byte_r;
  assign out_last_of_run      = out_last_r;
  assign out_from_replacement = out_repl_r;
  assign out_match_total      = out_total_r;

  `MSR_ASSERT_NOW(a_pos_bound, 1'b1, mp_r < MAX_L, "match position out of range")
  `MSR_ASSERT_NEXT(a_count_only_on_match, !(cmd.accept && full), $stable(count_r), "count moved")
  `MSR_ASSERT_NEXT(a_flush_clears, cmd.accept && in_func, mp_r == 4'd0, "flush left bytes held")

endmodule
`default_nettype wire

@@ src/masked_byte_search_replace.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_search_replace
// Masked byte pattern search and replace over a byte stream.
// ----------------------------------------------------------------------------
// Each input item is a data byte or an end-of-stream flush. Bytes that keep
// matching the search pattern (under the search mask) are held; a mismatch
// releases the held bytes plus the failing byte, a full match releases the
// replacement (leading bytes spliced with the matched bytes under the
// replace mask). An item that causes no result is taken without raising
// in_stall. An item that causes results holds in_stall high after it is
// taken, while the sequencer moves them one byte per cycle through the
// single output register; output stalls add to that. The input is taken
// again while the last result still waits in the output register. Write the
// configuration only while the block is idle.
// ----------------------------------------------------------------------------

module masked_byte_search_replace
  import msr_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_wdata,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_func,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_last_of_run,
  output logic        out_from_replacement,
  output logic [31:0] out_match_total
);

  dp_status_t st;
  dp_cmd_t    cmd;

  msr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  msr_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_func              (in_func),
    .in_data_byte         (in_data_byte),
    .cmd                  (cmd),
    .st                   (st),
    .out_byte             (out_out_byte),
    .out_last_of_run      (out_last_of_run),
    .out_from_replacement (out_from_replacement),
    .out_match_total      (out_match_total)
  );

endmodule
`default_nettype wire

@@ bench/masked_byte_search_replace_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_search_replace_tb
// Self-checking bench for the masked byte search and replace block.
// ----------------------------------------------------------------------------
// Byte streams go through the input channel. A predictor keeps its own copy of
// the registers, the held bytes, the match position and the match count, and
// queues the bytes that each accepted item should release. Every byte taken
// from the result channel is checked field by field against the oldest
// queued byte. The tests cover the reset settings, matching under masks,
// mismatch release without back-tracking, flush, splicing, deletion, length
// clamping, a search length lowered mid-match, random streams over random
// settings, a long output hold and a final stretch without idling.
// ----------------------------------------------------------------------------

module masked_byte_search_replace_tb;
  import msr_pkg::*;

  localparam int MAX_PAT = 8;
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT = 20000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam longint TIMEOUT_NS = 10_000_000;

  // One released byte as seen on the result channel
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        repl;
    logic [31:0] total;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_out_byte;
  logic        out_last_of_run;
  logic        out_from_replacement;
  logic [31:0] out_match_total;

  // Register copies, held at their reset values until written
  logic [63:0] cfg_search_pattern = '0;
  logic [63:0] cfg_search_mask = '1;
  logic [3:0]  cfg_search_len = 4'd1;
  logic [63:0] cfg_replace_pattern = '0;
  logic [63:0] cfg_replace_mask = '0;
  logic [3:0]  cfg_replace_len = 4'd0;
  logic [3:0]  cfg_splice_len = 4'd0;

  // Search state copy
  logic [7:0]  held [MAX_PAT];
  int unsigned match_pos = 0;
  logic [31:0] match_cnt = '0;

  stream_byte_t released_q[$];
  int unsigned  mismatch_count = 0;
  bit           gaps_on = 1'b1;
  bit           long_hold_req = 1'b0;

  masked_byte_search_replace DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_out_byte         (out_out_byte),
    .out_last_of_run      (out_last_of_run),
    .out_from_replacement (out_from_replacement),
    .out_match_total      (out_match_total)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out the bytes that one accepted item releases and queue them
  function automatic void predict_release(input logic func, input logic [7:0] b);
    int unsigned  slen, rlen, splen, pos, i;
    logic [7:0]   m, r, rm;
    stream_byte_t run_q[$];
    stream_byte_t sb;
    slen = cfg_search_len;
    rlen = cfg_replace_len;
    splen = cfg_splice_len;
    if (slen < 1) slen = 1;
    if (slen > MAX_PAT) slen = MAX_PAT;
    if (rlen > MAX_PAT) rlen = MAX_PAT;
    if (splen > slen) splen = slen;
    if (splen > rlen) splen = rlen;
    pos = (match_pos >= MAX_PAT) ? MAX_PAT - 1 : match_pos;
    sb = '0;

    if (func == FUNC_FLUSH) begin
      // release whatever is held
      for (i = 0; i < pos; i++) begin
        sb.data = held[i];
        run_q.push_back(sb);
      end
      match_pos = 0;
    end else begin
      held[pos] = b;
      m = cfg_search_mask[8*pos +: 8];
      if ((b & m) != (cfg_search_pattern[8*pos +: 8] & m)) begin
        // mismatch: release held bytes and the failing one, no back-tracking
        for (i = 0; i <= pos; i++) begin
          sb.data = held[i];
          run_q.push_back(sb);
        end
        match_pos = 0;
      end else if (pos + 1 < slen) begin
        match_pos = pos + 1;
      end else begin
        // full match: count it and emit the replacement
        match_cnt++;
        sb.repl = 1'b1;
        for (i = 0; i < rlen; i++) begin
          r = cfg_replace_pattern[8*i +: 8];
          if (i < splen) begin
            rm = cfg_replace_mask[8*i +: 8];
            r = (r & rm) | (held[i] & ~rm);
          end
          sb.data = r;
          run_q.push_back(sb);
        end
        match_pos = 0;
      end
    end

    foreach (run_q[k]) begin
      run_q[k].total = match_cnt;
      run_q[k].last = (k == run_q.size() - 1);
      released_q.push_back(run_q[k]);
    end
  endfunction

  // Byte that continues the current partial match, free bits random
  function automatic logic [7:0] matching_byte();
    logic [7:0] m;
    m = cfg_search_mask[8*match_pos +: 8];
    return (cfg_search_pattern[8*match_pos +: 8] & m) | (8'($urandom) & ~m);
  endfunction

  // Mask with whole-byte extremes mixed in
  function automatic logic [63:0] rand_mask();
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < MAX_PAT; i++) begin
      case ($urandom_range(0, 3))
        0: w[8*i +: 8] = 8'h00;
        1: w[8*i +: 8] = 8'hff;
        default: w[8*i +: 8] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Offer one item, optionally after a gap, and predict it once taken
  task automatic send_item(input logic func, input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_release(func, b);
  endtask

  // Drop valid, wait for every queued byte, then let the block settle
  task automatic drain_and_settle();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (released_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (released_q.size() != 0) begin
      mismatch_count += released_q.size();
      $display("%0t ns: %0d bytes expected, none arrived", $time, released_q.size());
      released_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_SEARCH_PATTERN:  cfg_search_pattern = value;
      REG_SEARCH_MASK:     cfg_search_mask = value;
      REG_SEARCH_LENGTH:   cfg_search_len = value[3:0];
      REG_REPLACE_PATTERN: cfg_replace_pattern = value;
      REG_REPLACE_MASK:    cfg_replace_mask = value;
      REG_REPLACE_LENGTH:  cfg_replace_len = value[3:0];
      REG_SPLICE_LENGTH:   cfg_splice_len = value[3:0];
      default: ;
    endcase
  endtask

  // Write all registers while idle; junk above the length nibbles
  task automatic set_config(input logic [63:0] sp, input logic [63:0] sm, input logic [3:0] sl,
                            input logic [63:0] rp, input logic [63:0] rm, input logic [3:0] rl,
                            input logic [3:0] spl);
    drain_and_settle();
    write_reg(REG_SEARCH_PATTERN, sp);
    write_reg(REG_SEARCH_MASK, sm);
    write_reg(REG_SEARCH_LENGTH, {60'({$urandom, $urandom}), sl});
    write_reg(REG_REPLACE_PATTERN, rp);
    write_reg(REG_REPLACE_MASK, rm);
    write_reg(REG_REPLACE_LENGTH, {60'({$urandom, $urandom}), rl});
    write_reg(REG_SPLICE_LENGTH, {60'({$urandom, $urandom}), spl});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_random_config();
    logic [3:0] sl;
    case ($urandom_range(0, 9))
      0: sl = 4'd0;
      1: sl = 4'($urandom_range(9, 15));
      default: sl = 4'($urandom_range(1, 8));
    endcase
    set_config($urandom_range(0, 5) == 0 ? '1 : {$urandom, $urandom}, rand_mask(), sl,
               {$urandom, $urandom}, rand_mask(), 4'($urandom_range(0, 15)),
               4'($urandom_range(0, 15)));
  endtask

  // Mostly bytes that extend the match, some noise and flushes
  task automatic send_random_stream(input int n);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)
        send_item(FUNC_FLUSH, 8'($urandom));
      else if (pick < 75)
        send_item(FUNC_DATA, matching_byte());
      else
        send_item(FUNC_DATA, 8'($urandom));
    end
  endtask

  // Reset settings: a single zero byte matches and is deleted
  task automatic test_reset_defaults();
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_DATA, 8'h01);
    send_item(FUNC_FLUSH, 8'hff);
  endtask

  // Three-byte search, case-blind middle byte, spliced replacement
  task automatic test_match_and_mismatch();
    set_config(64'h0000_0000_0043_4241, 64'hffff_ffff_ffff_dfff, 4'd3,
               64'h0000_0000_5a59_5857, 64'h0000_0000_0000_20ff, 4'd4, 4'd2);
    send_item(FUNC_DATA, 8'h41);
    send_item(FUNC_DATA, 8'h62);
    send_item(FUNC_DATA, 8'h43);
    // a restart inside a failed partial match is missed
    send_item(FUNC_DATA, 8'h41);
    send_item(FUNC_DATA, 8'h41);
    send_item(FUNC_DATA, 8'h42);
    send_item(FUNC_DATA, 8'h43);
    // flush with bytes held, then with nothing held
    send_item(FUNC_DATA, 8'h41);
    send_item(FUNC_DATA, 8'h42);
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_FLUSH, 8'hff);
    send_item(FUNC_DATA, 8'hff);
  endtask

  // Lengths beyond range are clamped; all-zero search mask matches anything
  task automatic test_length_extremes();
    set_config('1, '0, 4'd0, '1, '1, 4'd15, 4'd15);
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_DATA, 8'hff);
    set_config({$urandom, $urandom}, '0, 4'd15, '0, '0, 4'd8, 4'd8);
    for (int k = 0; k < MAX_PAT; k++)
      send_item(FUNC_DATA, 8'($urandom));
  endtask

  // Lower the search length while bytes are held: next match completes
  task automatic test_shortened_search();
    set_config(64'h8877_6655_4433_2211, '1, 4'd5,
               64'hf0e0_d0c0_b0a0_9080, 64'h0000_0000_0000_0f0f, 4'd3, 4'd15);
    send_item(FUNC_DATA, 8'h11);
    send_item(FUNC_DATA, 8'h22);
    send_item(FUNC_DATA, 8'h33);
    set_config(64'h8877_6655_4433_2211, '1, 4'd2,
               64'hf0e0_d0c0_b0a0_9080, 64'h0000_0000_0000_0f0f, 4'd3, 4'd15);
    send_item(FUNC_DATA, 8'h44);
  endtask

  task automatic test_random_streams();
    for (int c = 0; c < 8; c++) begin
      set_random_config();
      send_random_stream(30);
    end
  endtask

  // Hold the output for a long stretch while items keep coming
  task automatic test_long_hold();
    set_config('0, '0, 4'd1, {$urandom, $urandom}, rand_mask(), 4'd8, 4'd3);
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    for (int k = 0; k < 30; k++)
      send_item(FUNC_DATA, 8'($urandom));
    gaps_on = 1'b1;
  endtask

  task automatic test_quiet_tail();
    set_random_config();
    gaps_on = 1'b0;
    send_random_stream(50);
  endtask

  // Receiver stall: random bursts, or one long hold on request
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Check each byte taken against the oldest queued one
  always @(posedge clk) begin
    stream_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (released_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: no byte expected, got out_byte %02h", $time, out_out_byte);
      end else begin
        want = released_q.pop_front();
        check_field("out_byte", want.data, out_out_byte);
        check_field("last_of_run", want.last, out_last_of_run);
        check_field("from_replacement", want.repl, out_from_replacement);
        check_field("match_total", want.total, out_match_total);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[masked_byte_search_replace] ERROR");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_func <= FUNC_DATA;
    in_data_byte <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_match_and_mismatch();
    test_length_extremes();
    test_shortened_search();
    test_random_streams();
    test_long_hold();
    test_quiet_tail();
    drain_and_settle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0)
      $display("[masked_byte_search_replace] OK");
    else
      $display("[masked_byte_search_replace] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/msr_pkg.sv
src/msr_ctrl.sv
src/msr_dp.sv
src/masked_byte_search_replace.sv
bench/masked_byte_search_replace_tb.sv
